>>> rtl/base64_line_wrapped_encoder_core_assert.svh
// Assertion macros used by the port-level checker b64le_chk.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef BASE64_LINE_WRAPPED_ENCODER_CORE_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define B64LE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define B64LE_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/b64le_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_pkg
// Shared constants, types and the Base64 alphabet for the line-wrapped
// encoder.
// ---------------------------------------------------------------------------
package b64le_pkg;

    localparam int unsigned MaxChars = 5;

    localparam logic [7:0] CharLf  = 8'h0A;
    localparam logic [7:0] CharPad = 8'h3D;

    localparam logic [7:0] LineLimitReset = 8'd72;

    // register offsets, in units of 32-bit words
    localparam logic [0:0] RegLineLimit = 1'b0;

    // characters produced by one byte, oldest in entry 0
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [2:0]               count;
        logic                     fin;
    } t_char_grp;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] enc6(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

>>> rtl/b64le_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_if
// Valid/ready channels for message bytes and encoded characters.
// ---------------------------------------------------------------------------
interface b64le_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64le_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       final_char;

    modport source (output valid, output out_char, output final_char, input ready);
    modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

>>> rtl/b64le_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_cfg
// APB register file: holds the line length limit.
// ---------------------------------------------------------------------------
module b64le_cfg
    import b64le_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_line_limit
);

    logic [7:0] r_line_limit;
    logic       w_hit;

    assign w_hit  = (paddr[2] == RegLineLimit);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LineLimitReset;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_line_limit <= pwdata[7:0];
        end
    end

    assign prdata       = w_hit ? {24'd0, r_line_limit} : 32'd0;
    assign o_line_limit = r_line_limit;

endmodule

>>> rtl/b64le_enc.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_enc
// Input register, group/line state and the encode logic that turns one
// byte into its group of output characters.
// ---------------------------------------------------------------------------
module b64le_enc
    import b64le_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_line_limit,
    b64le_in_if.sink       i_in,
    input  logic           i_buf_free,
    output logic           o_load,
    output t_char_grp      o_grp
);

    logic        r_vld;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [15:0] r_held;
    logic [1:0]  r_gcnt;
    logic [7:0]  r_lcnt;

    logic [15:0] n_held;
    logic [1:0]  n_gcnt;
    logic [7:0]  n_lcnt;
    t_char_grp   w_grp;
    logic        w_adv;
    logic [8:0]  w_sum;
    logic        w_lf;
    logic [7:0]  w_b0;
    logic [7:0]  w_b1;

    always_comb begin
        w_grp       = '0;
        w_grp.fin   = r_last;
        n_held      = {r_held[7:0], r_byte};
        n_gcnt      = r_gcnt + 2'd1;
        n_lcnt      = r_lcnt;
        w_sum       = {1'b0, r_lcnt} + 9'd4;
        w_lf        = (w_sum >= {1'b0, i_line_limit}) || w_sum[8];
        w_b0        = r_held[15:8];
        w_b1        = r_held[7:0];

        if (r_gcnt == 2'd2) begin
            w_grp.chars[0] = enc6(w_b0[7:2]);
            w_grp.chars[1] = enc6({w_b0[1:0], w_b1[7:4]});
            w_grp.chars[2] = enc6({w_b1[3:0], r_byte[7:6]});
            w_grp.chars[3] = enc6(r_byte[5:0]);
            w_grp.chars[4] = CharLf;
            n_held         = '0;
            n_gcnt         = '0;
            n_lcnt         = w_lf ? 8'd0 : w_sum[7:0];
            // closing line feed only when the line is still open
            w_grp.count    = (w_lf || r_last) ? 3'd5 : 3'd4;
        end else if (r_last) begin
            if (r_gcnt == 2'd0) begin
                w_grp.chars[0] = enc6(r_byte[7:2]);
                w_grp.chars[1] = enc6({r_byte[1:0], 4'd0});
                w_grp.chars[2] = CharPad;
            end else begin
                w_grp.chars[0] = enc6(w_b1[7:2]);
                w_grp.chars[1] = enc6({w_b1[1:0], r_byte[7:4]});
                w_grp.chars[2] = enc6({r_byte[3:0], 2'd0});
            end
            w_grp.chars[3] = CharPad;
            w_grp.chars[4] = CharLf;
            w_grp.count    = 3'd5;
        end

        if (r_last) begin
            n_held = '0;
            n_gcnt = '0;
            n_lcnt = '0;
        end
    end

    // bytes that give no characters move on without waiting for the buffer
    assign w_adv      = r_vld && ((w_grp.count == 3'd0) || i_buf_free);
    assign i_in.ready = !r_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_held <= '0;
            r_gcnt <= '0;
            r_lcnt <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_vld <= 1'b1;
            end else if (w_adv) begin
                r_vld <= 1'b0;
            end
            if (w_adv) begin
                r_held <= n_held;
                r_gcnt <= n_gcnt;
                r_lcnt <= n_lcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last_byte;
        end
    end

    assign o_load = w_adv && (w_grp.count != 3'd0);
    assign o_grp  = w_grp;

endmodule

>>> rtl/b64le_ser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_ser
// Result buffer: holds one group of characters and shifts them out one
// word per cycle while o_out is ready.
// ---------------------------------------------------------------------------
module b64le_ser
    import b64le_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_char_grp   i_grp,
    output logic        o_buf_free,
    b64le_out_if.source o_out
);

    logic [MaxChars-1:0][7:0] r_chars;
    logic [2:0]               r_cnt;
    logic                     r_fin;
    logic                     w_pop;

    assign w_pop      = o_out.valid && o_out.ready;
    assign o_buf_free = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_grp.chars;
            r_fin   <= i_grp.fin;
        end else if (w_pop) begin
            // advance the head
            r_chars <= {8'h00, r_chars[MaxChars-1:1]};
        end
    end

    assign o_out.valid      = (r_cnt != 3'd0);
    assign o_out.out_char   = r_chars[0];
    assign o_out.final_char = r_fin && (r_cnt == 3'd1);

endmodule

>>> rtl/base64_line_wrapped_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_line_wrapped_encoder_core
// Byte-stream Base64 encoder with line feeds inserted at a set line length.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries message bytes (data_byte) with last_byte set on the final
//   byte. o_out carries one ASCII character per word; final_char marks the
//   closing line feed of each message. The APB port holds line_limit at
//   byte address 0 (reset value 72).
//   A byte is held in an input register and encoded in one pass into a
//   group of up to five characters, which a result buffer sends one per
//   cycle while o_out is ready. The first character of a group is valid
//   once the byte that completes it has passed the input register and the
//   group has been loaded into the result buffer, which waits until the
//   buffer is free. Throughput is set by the one-word-per-cycle output: a
//   three-byte group gives four or five characters, and a short message
//   costs more, as a one-byte message gives five characters.
//   When o_out stalls, the buffer holds its characters and i_in keeps
//   taking bytes until a byte that yields characters waits in the input
//   register; ready then drops.
//   Reset clears the group and line state; line_limit returns to 72.
// ---------------------------------------------------------------------------
module base64_line_wrapped_encoder_core
    import b64le_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64le_in_if.sink    i_in,
    b64le_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] w_line_limit;
    logic       w_load;
    logic       w_buf_free;
    t_char_grp  w_grp;

    b64le_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_line_limit (w_line_limit)
    );

    b64le_enc u_enc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_limit (w_line_limit),
        .i_in         (i_in),
        .i_buf_free   (w_buf_free),
        .o_load       (w_load),
        .o_grp        (w_grp)
    );

    b64le_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_grp      (w_grp),
        .o_buf_free (w_buf_free),
        .o_out      (o_out)
    );

endmodule

>>> rtl/b64le_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_chk
// Port-level checker for the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_core_assert.svh"

module b64le_chk
    import b64le_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_final_char,
    input logic       i_pready
);

    // the encoded message always closes with a line feed
    `B64LE_ASSERT(a_final_is_lf, (i_out_valid && i_final_char) |-> (i_out_char == CharLf), "final character is not a line feed")

    `B64LE_NEVER(a_pready_low, !i_pready, "pready dropped")

    `B64LE_ASSERT(a_out_valid_hold, (i_out_valid && !i_out_ready) |=> i_out_valid, "output valid dropped while stalled")

    `B64LE_ASSERT(a_out_data_hold, (i_out_valid && !i_out_ready) |=> ($stable(i_out_char) && $stable(i_final_char)), "output word changed while stalled")

endmodule

bind base64_line_wrapped_encoder_core b64le_chk u_b64le_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_char   (o_out.out_char),
    .i_final_char (o_out.final_char),
    .i_pready     (pready)
);

>>> tb/b64le_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64le_stream_checker
// Watches the byte and character channels and the register port of the
// line-wrapped Base64 encoder. Predicts the characters of every accepted
// byte, then compares each accepted character word in order.
// ---------------------------------------------------------------------------
module b64le_stream_checker
    import b64le_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64le_in_if         in_ch,
    b64le_out_if        out_ch,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_chars_seen,
    output int unsigned o_msgs_seen
);

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } enc_char_t;

    localparam logic [8*64-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    enc_char_t   char_q[$];
    logic [7:0]  limit_reg;
    logic [15:0] held;
    logic [1:0]  held_cnt;
    logic [7:0]  line_fill;
    int unsigned fail_cnt;
    int unsigned pend_cnt;
    int unsigned chars_cnt;
    int unsigned msgs_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;
    assign o_chars_seen = chars_cnt;
    assign o_msgs_seen  = msgs_cnt;

    // first alphabet character sits in the top byte of the literal
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return Alphabet[(63 - v) * 8 +: 8];
    endfunction

    function automatic void predict_chars(input logic [7:0] b, input logic is_last);
        logic [7:0] ch[5];
        logic [7:0] hi;
        logic [7:0] lo;
        logic [8:0] sum;
        enc_char_t  e;
        int         n;
        n = 0;
        if (held_cnt == 2'd2) begin
            hi = held[15:8];
            lo = held[7:0];
            ch[0] = sextet_char(hi[7:2]);
            ch[1] = sextet_char({hi[1:0], lo[7:4]});
            ch[2] = sextet_char({lo[3:0], b[7:6]});
            ch[3] = sextet_char(b[5:0]);
            n = 4;
            // compare at full width so the line length never wraps
            sum = {1'b0, line_fill} + 9'd4;
            if (sum >= {1'b0, limit_reg} || sum > 9'd255) begin
                ch[n] = CharLf;
                n++;
                line_fill = '0;
            end else begin
                line_fill = sum[7:0];
            end
            if (is_last && line_fill != 8'd0) begin
                ch[n] = CharLf;
                n++;
            end
            held     = '0;
            held_cnt = '0;
        end else begin
            held     = {held[7:0], b};
            held_cnt = held_cnt + 2'd1;
            if (is_last) begin
                hi = held[15:8];
                lo = held[7:0];
                if (held_cnt == 2'd1) begin
                    ch[0] = sextet_char(b[7:2]);
                    ch[1] = sextet_char({b[1:0], 4'b0000});
                    ch[2] = CharPad;
                end else begin
                    ch[0] = sextet_char(hi[7:2]);
                    ch[1] = sextet_char({hi[1:0], lo[7:4]});
                    ch[2] = sextet_char({lo[3:0], 2'b00});
                end
                ch[3] = CharPad;
                ch[4] = CharLf;
                n = 5;
            end
        end
        for (int i = 0; i < n; i++) begin
            e.ch  = ch[i];
            e.fin = is_last && (i == n - 1);
            char_q.push_back(e);
        end
        if (is_last) begin
            held      = '0;
            held_cnt  = '0;
            line_fill = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        enc_char_t want;
        if (!i_rst_n) begin
            limit_reg = LineLimitReset;
            held      = '0;
            held_cnt  = '0;
            line_fill = '0;
            char_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == {RegLineLimit, 2'b00}) begin
                limit_reg = i_pwdata[7:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_chars(in_ch.data_byte, in_ch.last_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (char_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected word: expected none, got char 0x%02h final %0b",
                             $time, out_ch.out_char, out_ch.final_char);
                end else begin
                    want = char_q.pop_front();
                    chars_cnt++;
                    if (want.ch !== out_ch.out_char || want.fin !== out_ch.final_char) begin
                        fail_cnt++;
                        $display("%0t: mismatch: expected char 0x%02h final %0b,",
                                 $time, want.ch, want.fin);
                        $display("%0t:           got char 0x%02h final %0b",
                                 $time, out_ch.out_char, out_ch.final_char);
                    end
                    if (out_ch.final_char === 1'b1) begin
                        msgs_cnt++;
                    end
                end
            end
        end
        pend_cnt = char_q.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the line-wrapped Base64 encoder. Sends directed
// and random messages under several line limits with random source gaps and
// sink stalls; a separate checker predicts and compares every character.
// ---------------------------------------------------------------------------
module tb;
    import b64le_pkg::*;

    localparam int unsigned CycleLimit = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64le_in_if  in_if ();
    b64le_out_if out_if ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned chars_seen;
    int unsigned msgs_seen;
    int unsigned bytes_sent;
    int unsigned limits_used;
    int unsigned cycle_cnt;
    bit          src_gaps;
    bit          snk_stalls;

    always #1 clk = ~clk;

    base64_line_wrapped_encoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    b64le_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_if),
        .out_ch       (out_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars_seen (chars_seen),
        .o_msgs_seen  (msgs_seen)
    );

    // sink side: hold ready low in random bursts while snk_stalls is set
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (snk_stalls && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 6);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < CycleLimit) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Timed out after %0d cycles with %0d characters outstanding",
                 cycle_cnt, pending);
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= is_last;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic send_msg(input int unsigned len);
        int unsigned r;
        logic [7:0]  b;
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(0, 7);
            b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    // write only with the encoder drained and quiet
    task automatic set_line_limit(input logic [7:0] v);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {RegLineLimit, 2'b00};
        pwdata  <= {24'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits_used++;
    endtask

    initial begin
        logic [7:0]  lim;
        int unsigned budget;
        int unsigned len;
        int unsigned r;
        bit          quiet;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        src_gaps        = 1'b1;
        snk_stalls      = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset limit: one- and two-byte tails, full group on the last byte,
        // a group followed by a one-byte tail
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0); send_byte(8'h6E, 1'b1);
        send_byte(8'hFB, 1'b0); send_byte(8'hEF, 1'b0); send_byte(8'hBE, 1'b0);
        send_byte(8'h80, 1'b1);
        release_input();

        // smallest limit: the wrap feed carries the final mark, and a tail
        // on an empty line still gets its closing feed
        set_line_limit(8'd4);
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0);
        send_byte(8'h7F, 1'b0); send_byte(8'hFE, 1'b1);
        send_byte(8'h55, 1'b1);
        release_input();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    lim = 8'd252;
                end
                1: begin
                    lim = 8'd4;
                end
                2: begin
                    lim = 8'd5;
                end
                3: begin
                    lim = 8'($urandom_range(6, 40));
                end
                4: begin
                    lim = 8'($urandom_range(4, 252));
                end
                default: begin
                    lim = 8'($urandom_range(4, 24));
                end
            endcase
            set_line_limit(lim);
            quiet = (ph == 5);
            src_gaps   = !quiet;
            snk_stalls = !quiet;
            // long enough to wrap at the widest limit
            if (ph == 0) begin
                send_msg(195);
            end
            budget = bytes_sent + 24;
            while (bytes_sent < budget) begin
                src_gaps   = !quiet && $urandom_range(0, 2) != 0;
                snk_stalls = !quiet && $urandom_range(0, 2) != 0;
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    len = $urandom_range(1, 12);
                end else if (r < 9) begin
                    len = 3 * $urandom_range(1, 8);
                end else begin
                    len = $urandom_range(13, 40);
                end
                send_msg(len);
            end
            release_input();
        end

        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Sent %0d bytes and checked %0d characters over %0d messages",
                 bytes_sent, chars_seen, msgs_seen);
        $display("Used %0d line limits from 4 to 252, with and without gaps and stalls",
                 limits_used + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
